FILE: design/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared sizes, operation codes and status codes of the keyframe interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

   // table geometry (powers of two)
   localparam int PROPERTIES = 8;
   localparam int KEYFRAMES  = 16;
   localparam int CHANNELS   = 8;

   localparam int PROP_W  = $clog2(PROPERTIES);
   localparam int KF_W    = $clog2(KEYFRAMES);
   localparam int CH_W    = $clog2(CHANNELS);
   localparam int CC_W    = CH_W + 1;
   localparam int TIME_DEPTH  = PROPERTIES * KEYFRAMES;
   localparam int VALUE_DEPTH = PROPERTIES * KEYFRAMES * CHANNELS;

   // Q16.16 data and interpolation fraction widths
   localparam int DATA_W = 32;
   localparam int FRAC_W = 31;
   localparam int DIFF_W = DATA_W + 1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_WRITE = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXACT     = 2'd1,
      STATUS_NOBRACKET = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

endpackage

`default_nettype wire

FILE: design/keyframe_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core
// Keyframe tables per property with exact lookup and linear interpolation.
// ----------------------------------------------------------------------------
// One item at a time. Keyframe times sit in a 128-entry RAM and channel values
// in a 1024-entry RAM, both with registered reads; valid bits and per-property
// channel counts are flip-flops. A clear is applied in the dispatch state. A
// write scans the property's 16 time entries, then writes all 8 channels of
// a new keyframe, zero but for the written one. A query scans the same way,
// then an exact hit reads and emits one result per channel; an interpolation
// runs the serial divider for the fraction and then, per channel, two value
// reads and the 4-stage multiply pipeline. req_stall is high while an item is
// in work; a finished result waits in the output register without blocking
// the next transfer.
`default_nettype none

module keyframe_linear_interpolator_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic        [1:0]                  req_operation,
   input  wire logic        [kli_pkg::PROP_W-1:0]  req_property_index,
   input  wire logic signed [kli_pkg::DATA_W-1:0]  req_key_time,
   input  wire logic        [kli_pkg::CH_W-1:0]    req_channel,
   input  wire logic signed [kli_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed      [kli_pkg::DATA_W-1:0]  rsp_result_value,
   output logic             [kli_pkg::CH_W-1:0]    rsp_result_channel,
   output logic                                    rsp_last,
   output logic             [1:0]                  rsp_status
);
   import kli_pkg::*;

   localparam int TA_W = $clog2(TIME_DEPTH);
   localparam int VA_W = $clog2(VALUE_DEPTH);
   localparam logic [PROP_W:0] PROP_LIMIT = (PROP_W + 1)'(PROPERTIES);
   localparam logic [CH_W:0]   CH_LIMIT   = (CH_W + 1)'(CHANNELS);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_DISPATCH = 15'b000000000000010,
      ST_SCAN     = 15'b000000000000100,
      ST_DECIDE   = 15'b000000000001000,
      ST_WR_FILL  = 15'b000000000010000,
      ST_WR_ONE   = 15'b000000000100000,
      ST_EMIT     = 15'b000000001000000,
      ST_EX_RD    = 15'b000000010000000,
      ST_EX_OUT   = 15'b000000100000000,
      ST_DIV      = 15'b000001000000000,
      ST_IP_RDX   = 15'b000010000000000,
      ST_IP_RDY   = 15'b000100000000000,
      ST_IP_CAP   = 15'b001000000000000,
      ST_IP_WAIT  = 15'b010000000000000,
      ST_IP_OUT   = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // latched item
   logic [1:0]               op_ff;
   logic [PROP_W-1:0]        p_ff;
   logic signed [DATA_W-1:0] t_ff, v_ff;
   logic [CH_W-1:0]          ch_ff;

   // flip-flop state, one valid mask per property
   logic [KEYFRAMES-1:0]     valid_ff [PROPERTIES];
   logic [KEYFRAMES-1:0]     valid_in [PROPERTIES];
   logic [CC_W-1:0]          cc_ff [PROPERTIES];
   logic [CC_W-1:0]          cc_in [PROPERTIES];

   // scan bookkeeping
   logic [KF_W:0]            scan_ff, scan_in;
   logic                     pend_ff, pend_in;
   logic [KF_W-1:0]          pidx_ff, pidx_in;
   logic                     hit_ff, hit_in, free_ff, free_in;
   logic [KF_W-1:0]          hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic                     lo_ff, lo_in, hi_ff, hi_in;
   logic [KF_W-1:0]          lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic signed [DATA_W-1:0] lo_t_ff, lo_t_in, hi_t_ff, hi_t_in;

   logic [CH_W-1:0]          chc_ff, chc_in;
   logic signed [DATA_W-1:0] x_ff, x_in;

   // pending single result
   logic signed [DATA_W-1:0] pr_value_ff, pr_value_in;
   logic [CH_W-1:0]          pr_channel_ff, pr_channel_in;
   logic [1:0]               pr_status_ff, pr_status_in;

   // output register
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic [CH_W-1:0]          out_channel_ff;
   logic                     out_last_ff;
   logic [1:0]               out_status_ff;
   logic                     emit, emit_last;
   logic signed [DATA_W-1:0] emit_value;
   logic [CH_W-1:0]          emit_channel;
   logic [1:0]               emit_status;
   logic                     out_free;

   // memory ports
   logic                     t_we, t_re, v_we, v_re;
   logic [TA_W-1:0]          t_waddr, t_raddr;
   logic [VA_W-1:0]          v_waddr, v_raddr;
   logic [DATA_W-1:0]        t_wdata, t_rdata, v_wdata, v_rdata;
   logic signed [DATA_W-1:0] kt;

   // arithmetic units
   logic                     div_start, div_done;
   logic [DIFF_W-1:0]        div_dt, div_span;
   logic [FRAC_W-1:0]        frac;
   logic                     lerp_start, lerp_done;
   logic signed [DATA_W-1:0] lerp_result;

   logic                     accept, p_ok, ch_ok, kv, last_ch;
   logic [CC_W-1:0]          cc_cur, cc_need;

   kli_ram #(.WIDTH(DATA_W), .DEPTH(TIME_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   kli_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_en   (v_re),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   kli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dt),
      .divisor  (div_span),
      .done     (div_done),
      .quotient (frac)
   );

   kli_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .x      (x_ff),
      .y      (v_rdata),
      .frac   (frac),
      .done   (lerp_done),
      .result (lerp_result)
   );

   // handshake and decode helpers
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign p_ok      = {1'b0, p_ff} < PROP_LIMIT;
   assign ch_ok     = {1'b0, ch_ff} < CH_LIMIT;
   assign kt        = t_rdata;
   assign kv        = valid_ff[p_ff][pidx_ff];
   assign cc_cur    = cc_ff[p_ff];
   assign cc_need   = {1'b0, ch_ff} + CC_W'(1);
   assign last_ch   = ({1'b0, chc_ff} + CC_W'(1)) == cc_cur;
   assign div_dt    = DIFF_W'(t_ff) - DIFF_W'(lo_t_ff);
   assign div_span  = DIFF_W'(hi_t_ff) - DIFF_W'(lo_t_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      cc_in         = cc_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      lo_in         = lo_ff;
      lo_idx_in     = lo_idx_ff;
      lo_t_in       = lo_t_ff;
      hi_in         = hi_ff;
      hi_idx_in     = hi_idx_ff;
      hi_t_in       = hi_t_ff;
      chc_in        = chc_ff;
      x_in          = x_ff;
      pr_value_in   = pr_value_ff;
      pr_channel_in = pr_channel_ff;
      pr_status_in  = pr_status_ff;
      t_we          = 1'b0;
      t_waddr       = {p_ff, free_idx_ff};
      t_wdata       = t_ff;
      t_re          = 1'b0;
      t_raddr       = {p_ff, scan_ff[KF_W-1:0]};
      v_we          = 1'b0;
      v_waddr       = {p_ff, hit_idx_ff, ch_ff};
      v_wdata       = v_ff;
      v_re          = 1'b0;
      v_raddr       = {p_ff, hit_idx_ff, chc_ff};
      div_start     = 1'b0;
      lerp_start    = 1'b0;
      emit          = 1'b0;
      emit_value    = pr_value_ff;
      emit_channel  = pr_channel_ff;
      emit_last     = 1'b1;
      emit_status   = pr_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            pr_value_in   = '0;
            pr_channel_in = '0;
            scan_in       = '0;
            hit_in        = 1'b0;
            free_in       = 1'b0;
            lo_in         = 1'b0;
            hi_in         = 1'b0;
            unique case (op_ff)
               OP_CLEAR: begin
                  if (p_ok) begin
                     valid_in[p_ff] = '0;
                     cc_in[p_ff]    = '0;
                  end
                  pr_status_in = STATUS_OK;
                  state_in     = ST_EMIT;
               end
               OP_WRITE: begin
                  pr_channel_in = ch_ff;
                  if (!p_ok || !ch_ok) begin
                     pr_status_in = STATUS_FULL;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               OP_QUERY: begin
                  if (!p_ok || cc_cur == '0) begin
                     pr_status_in = STATUS_NOBRACKET;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // issue one time read per cycle, evaluate it the next
         ST_SCAN: begin
            if (!scan_ff[KF_W]) begin
               t_re    = 1'b1;
               pend_in = 1'b1;
               pidx_in = scan_ff[KF_W-1:0];
               scan_in = scan_ff + (KF_W + 1)'(1);
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
            if (pend_ff) begin
               if (op_ff == OP_WRITE) begin
                  if (kv) begin
                     if (!hit_ff && kt == t_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = pidx_ff;
                     end
                  end else if (!free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = pidx_ff;
                  end
               end else if (kv) begin
                  if (kt == t_ff) begin
                     if (!hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = pidx_ff;
                     end
                  end else if (kt < t_ff) begin
                     if (!lo_ff || kt > lo_t_ff) begin
                        lo_in     = 1'b1;
                        lo_idx_in = pidx_ff;
                        lo_t_in   = kt;
                     end
                  end else if (!hi_ff || kt < hi_t_ff) begin
                     hi_in     = 1'b1;
                     hi_idx_in = pidx_ff;
                     hi_t_in   = kt;
                  end
               end
            end
         end

         ST_DECIDE: begin
            chc_in = '0;
            if (op_ff == OP_WRITE) begin
               if (hit_ff) begin
                  state_in = ST_WR_ONE;
               end else if (free_ff) begin
                  t_we                        = 1'b1;
                  valid_in[p_ff][free_idx_ff] = 1'b1;
                  state_in                    = ST_WR_FILL;
               end else begin
                  pr_status_in = STATUS_FULL;
                  state_in     = ST_EMIT;
               end
            end else begin
               if (hit_ff) begin
                  state_in = ST_EX_RD;
               end else if (lo_ff && hi_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  pr_status_in = STATUS_NOBRACKET;
                  state_in     = ST_EMIT;
               end
            end
         end

         // new keyframe: zero every channel, written one gets the value
         ST_WR_FILL: begin
            v_we    = 1'b1;
            v_waddr = {p_ff, free_idx_ff, chc_ff};
            v_wdata = (chc_ff == ch_ff) ? v_ff : '0;
            chc_in  = chc_ff + CH_W'(1);
            if (chc_ff == CH_W'(CHANNELS - 1)) begin
               if (cc_cur < cc_need) begin
                  cc_in[p_ff] = cc_need;
               end
               pr_status_in = STATUS_OK;
               state_in     = ST_EMIT;
            end
         end

         ST_WR_ONE: begin
            v_we = 1'b1;
            if (cc_cur < cc_need) begin
               cc_in[p_ff] = cc_need;
            end
            pr_status_in = STATUS_OK;
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_EX_RD: begin
            v_re     = 1'b1;
            state_in = ST_EX_OUT;
         end

         ST_EX_OUT: begin
            emit_value   = v_rdata;
            emit_channel = chc_ff;
            emit_last    = last_ch;
            emit_status  = STATUS_EXACT;
            if (out_free) begin
               emit   = 1'b1;
               chc_in = chc_ff + CH_W'(1);
               state_in = last_ch ? ST_IDLE : ST_EX_RD;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IP_RDX;
            end
         end

         ST_IP_RDX: begin
            v_re     = 1'b1;
            v_raddr  = {p_ff, lo_idx_ff, chc_ff};
            state_in = ST_IP_RDY;
         end

         ST_IP_RDY: begin
            v_re     = 1'b1;
            v_raddr  = {p_ff, hi_idx_ff, chc_ff};
            x_in     = v_rdata;
            state_in = ST_IP_CAP;
         end

         ST_IP_CAP: begin
            lerp_start = 1'b1;
            state_in   = ST_IP_WAIT;
         end

         ST_IP_WAIT: begin
            if (lerp_done) begin
               pr_value_in = lerp_result;
               state_in    = ST_IP_OUT;
            end
         end

         ST_IP_OUT: begin
            emit_channel = chc_ff;
            emit_last    = last_ch;
            emit_status  = STATUS_OK;
            if (out_free) begin
               emit     = 1'b1;
               chc_in   = chc_ff + CH_W'(1);
               state_in = last_ch ? ST_IDLE : ST_IP_RDX;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < PROPERTIES; i++) begin
            valid_ff[i] <= '0;
            cc_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cc_ff    <= cc_in;
         pend_ff  <= pend_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         p_ff  <= req_property_index;
         t_ff  <= req_key_time;
         ch_ff <= req_channel;
         v_ff  <= req_value;
      end
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      lo_ff         <= lo_in;
      lo_idx_ff     <= lo_idx_in;
      lo_t_ff       <= lo_t_in;
      hi_ff         <= hi_in;
      hi_idx_ff     <= hi_idx_in;
      hi_t_ff       <= hi_t_in;
      chc_ff        <= chc_in;
      x_ff          <= x_in;
      pr_value_ff   <= pr_value_in;
      pr_channel_ff <= pr_channel_in;
      pr_status_ff  <= pr_status_in;
      if (emit) begin
         out_value_ff   <= emit_value;
         out_channel_ff <= emit_channel;
         out_last_ff    <= emit_last;
         out_status_ff  <= emit_status;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_value_ff;
   assign rsp_result_channel = out_channel_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_status         = out_status_ff;

endmodule

`default_nettype wire

FILE: design/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/kli_divider.sv
// ----------------------------------------------------------------------------
// kli_divider
// Restoring divider for the interpolation fraction floor(dt * 2^31 / span),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [kli_pkg::DIFF_W-1:0]    dividend,
   input  wire logic [kli_pkg::DIFF_W-1:0]    divisor,
   output logic                               done,
   output logic      [kli_pkg::FRAC_W-1:0]    quotient
);
   import kli_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic [DIFF_W:0]   rem_ff, rem_in, rem_sh;
   logic [DIFF_W-1:0] div_ff;
   logic [FRAC_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              ge;

   // one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff[DIFF_W-1:0], 1'b0};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, div_ff} : rem_sh;
         q_in   = {q_ff[FRAC_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

FILE: design/kli_lerp.sv
// ----------------------------------------------------------------------------
// kli_lerp
// Four-stage pipeline: x + round(|y - x| * f / 2^31) with the step's sign,
// saturated to 32 bits. The 33x31 product is split into two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_lerp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [kli_pkg::DATA_W-1:0]  x,
   input  wire logic signed [kli_pkg::DATA_W-1:0]  y,
   input  wire logic        [kli_pkg::FRAC_W-1:0]  frac,
   output logic                                    done,
   output logic signed      [kli_pkg::DATA_W-1:0]  result
);
   import kli_pkg::*;

   localparam int LO_W   = 16;
   localparam int HI_W   = DIFF_W - LO_W;
   localparam int PROD_W = 64;
   localparam int STEP_W = PROD_W - FRAC_W;
   localparam int SUM_W  = DATA_W + 2;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [DIFF_W-1:0]        mag1_ff;
   logic [FRAC_W-1:0]        f1_ff;
   logic signed [DATA_W-1:0] x1_ff, x2_ff, x3_ff;
   logic [LO_W+FRAC_W-1:0]   plo_ff;
   logic [HI_W+FRAC_W-1:0]   phi_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [DATA_W-1:0] res_ff;

   logic signed [DIFF_W-1:0] d;
   logic [PROD_W-1:0]        sum;
   logic signed [SUM_W-1:0]  r;

   // stage 1: difference and magnitude
   assign d = DIFF_W'(y) - DIFF_W'(x);

   // stage 3: recombine and round
   assign sum = {phi_ff, {LO_W{1'b0}}} + PROD_W'(plo_ff) + (PROD_W'(1) << (FRAC_W - 1));

   // stage 4: apply step and saturate
   assign r = neg3_ff ? SUM_W'(x3_ff) - $signed({1'b0, step_ff})
                      : SUM_W'(x3_ff) + $signed({1'b0, step_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff <= d[DIFF_W-1];
      mag1_ff <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      f1_ff   <= frac;
      x1_ff   <= x;
      // stage 2: partial products
      plo_ff  <= mag1_ff[LO_W-1:0] * f1_ff;
      phi_ff  <= mag1_ff[DIFF_W-1:LO_W] * f1_ff;
      neg2_ff <= neg1_ff;
      x2_ff   <= x1_ff;
      step_ff <= sum[PROD_W-1:FRAC_W];
      neg3_ff <= neg2_ff;
      x3_ff   <= x2_ff;
      if (r > SUM_W'(32'sh7fffffff)) begin
         res_ff <= 32'sh7fffffff;
      end else if (r < -SUM_W'(33'sh080000000)) begin
         res_ff <= 32'sh80000000;
      end else begin
         res_ff <= r[DATA_W-1:0];
      end
   end

   assign done   = v4_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

FILE: design/kli_checker.sv
// ----------------------------------------------------------------------------
// kli_checker
// Port-level checks of the interpolator's result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [kli_pkg::DATA_W-1:0] rsp_result_value,
   input wire logic        [kli_pkg::CH_W-1:0]   rsp_result_channel,
   input wire logic                              rsp_last,
   input wire logic        [1:0]                 rsp_status
);
   import kli_pkg::*;

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // no bracket is a single zero result
   a_nobracket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOBRACKET |->
         rsp_last && rsp_result_value == '0 && rsp_result_channel == '0)
      else $error("bad no-bracket result");

   // table full is a single zero result
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_last && rsp_result_value == '0)
      else $error("bad table-full result");

   // only query data results continue past one
   a_multi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_OK || rsp_status == STATUS_EXACT)
      else $error("non-final result with single-result status");

endmodule

bind keyframe_linear_interpolator_core kli_checker u_kli_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe linear interpolator core: a behavioral
// keyframe table model predicts every response, a monitor compares them field
// by field, and named tests run directed cases, random traffic and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kli_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [CH_W-1:0]          chan;
      logic                     last;
      logic [1:0]               status;
   } answer_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic [PROP_W-1:0] req_property_index = '0;
   logic signed [DATA_W-1:0] req_key_time = '0;
   logic [CH_W-1:0] req_channel = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [CH_W-1:0] rsp_result_channel;
   logic rsp_last;
   logic [1:0] rsp_status;

   // model state
   logic                     kf_used [PROPERTIES][KEYFRAMES];
   logic signed [DATA_W-1:0] kf_time [PROPERTIES][KEYFRAMES];
   logic signed [DATA_W-1:0] kf_val  [PROPERTIES][KEYFRAMES][CHANNELS];
   int unsigned              chan_cnt [PROPERTIES];

   answer_type pending_answers[$];
   int  failures = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyframe_linear_interpolator_core i_dut (.*);

   // interpolation between two keyframes, saturated
   function automatic logic signed [DATA_W-1:0] blend(longint t, longint lo, longint hi,
                                                      longint x, longint y);
      longint unsigned dt, span, f, mag, stp;
      longint d, r;
      dt = t - lo;
      span = hi - lo;
      f = (dt << 31) / span;
      d = y - x;
      mag = (d < 0) ? -d : d;
      stp = (mag * f + (64'd1 << 30)) >> 31;
      r = (d < 0) ? x - longint'(stp) : x + longint'(stp);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[DATA_W-1:0];
   endfunction

   function automatic void push_answer(logic signed [DATA_W-1:0] v, int unsigned ch,
                                       logic lst, status_type st);
      answer_type a;
      a.value = v; a.chan = ch[CH_W-1:0]; a.last = lst; a.status = st;
      pending_answers = {pending_answers, a};
   endfunction

   // update tables and queue the responses of one transfer
   function automatic void predict_table_op(logic [1:0] op, int unsigned p,
                                            logic signed [DATA_W-1:0] t,
                                            int unsigned ch, logic signed [DATA_W-1:0] v);
      int slot, free_slot, lo, hi, ex;
      int unsigned n;
      slot = -1; free_slot = -1; lo = -1; hi = -1; ex = -1;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < KEYFRAMES; i++) kf_used[p][i] = 1'b0;
            chan_cnt[p] = 0;
            push_answer('0, 0, 1'b1, STATUS_OK);
         end
         OP_WRITE: begin
            for (int i = 0; i < KEYFRAMES; i++) begin
               if (kf_used[p][i]) begin
                  if (slot < 0 && kf_time[p][i] == t) slot = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (slot < 0 && free_slot < 0) begin
               push_answer('0, ch, 1'b1, STATUS_FULL);
               return;
            end
            if (slot < 0) begin
               slot = free_slot;
               kf_used[p][slot] = 1'b1;
               kf_time[p][slot] = t;
               for (int i = 0; i < CHANNELS; i++) kf_val[p][slot][i] = '0;
            end
            kf_val[p][slot][ch] = v;
            if (chan_cnt[p] < ch + 1) chan_cnt[p] = ch + 1;
            push_answer('0, ch, 1'b1, STATUS_OK);
         end
         OP_QUERY: begin
            n = chan_cnt[p];
            if (n == 0) begin
               push_answer('0, 0, 1'b1, STATUS_NOBRACKET);
               return;
            end
            for (int i = 0; i < KEYFRAMES; i++) begin
               if (!kf_used[p][i]) continue;
               if (kf_time[p][i] == t) begin
                  if (ex < 0) ex = i;
               end else if (kf_time[p][i] < t) begin
                  if (lo < 0 || kf_time[p][i] > kf_time[p][lo]) lo = i;
               end else begin
                  if (hi < 0 || kf_time[p][i] < kf_time[p][hi]) hi = i;
               end
            end
            if (ex >= 0) begin
               for (int i = 0; i < n; i++)
                  push_answer(kf_val[p][ex][i], i, i + 1 == n, STATUS_EXACT);
            end else if (lo < 0 || hi < 0) begin
               push_answer('0, 0, 1'b1, STATUS_NOBRACKET);
            end else begin
               for (int i = 0; i < n; i++)
                  push_answer(blend(t, kf_time[p][lo], kf_time[p][hi],
                                    kf_val[p][lo][i], kf_val[p][hi][i]),
                              i, i + 1 == n, STATUS_OK);
            end
         end
         default: ;
      endcase
   endfunction

   // offer one transfer and wait until it is taken
   task automatic send_item(logic [1:0] op, int unsigned p,
                            logic signed [DATA_W-1:0] t, int unsigned ch,
                            logic signed [DATA_W-1:0] v);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_property_index <= PROP_W'(p);
      req_key_time <= t;
      req_channel <= CH_W'(ch);
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_table_op(op, p & (PROPERTIES - 1), t, ch & (CHANNELS - 1), v);
   endtask

   // receiver stall pattern, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("response with nothing expected");
            failures++;
         end else begin
            answer_type a;
            a = pending_answers.pop_front();
            if (rsp_result_value !== a.value) begin
               $error("result_value expected %0d got %0d", a.value, rsp_result_value);
               failures++;
            end
            if (rsp_result_channel !== a.chan) begin
               $error("result_channel expected %0d got %0d", a.chan, rsp_result_channel);
               failures++;
            end
            if (rsp_last !== a.last) begin
               $error("last expected %0d got %0d", a.last, rsp_last);
               failures++;
            end
            if (rsp_status !== a.status) begin
               $error("status expected %0d got %0d", a.status, rsp_status);
               failures++;
            end
         end
      end
   end

   // stop offering and wait for every expected response
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      send_item(OP_QUERY, 0, 0, 0, 0);                   // empty table
      send_item(OP_WRITE, 0, 32'sh80000000, 7, 32'sh7fffffff);
      send_item(OP_WRITE, 0, 32'sh7fffffff, 0, 32'sh80000000);
      send_item(OP_WRITE, 0, 32'sh7fffffff, 7, 32'sh80000000);
      send_item(OP_WRITE, 0, 32'sh80000000, 0, 32'sh7fffffff);
      send_item(OP_QUERY, 0, 0, 0, 0);                   // interpolate, saturate path
      send_item(OP_QUERY, 0, 32'sh80000000, 0, 0);       // exact at min
      send_item(OP_QUERY, 0, 32'sh7fffffff, 0, 0);       // exact at max
      send_item(OP_WRITE, 1, 32'sh00010000, 2, 32'sh00050000);
      send_item(OP_QUERY, 1, 32'sh00020000, 0, 0);       // one-sided
      send_item(OP_QUERY, 1, 0, 0, 0);                   // one-sided below
      send_item(OP_NONE, 1, 0, 0, 0);                    // ignored
      for (int i = 0; i < KEYFRAMES + 1; i++)            // fill to full
         send_item(OP_WRITE, 2, i * 32'sh00010000, i, -i);
      send_item(OP_QUERY, 2, 32'sh00018000, 0, 0);
      send_item(OP_CLEAR, 2, 0, 0, 0);
      send_item(OP_QUERY, 2, 32'sh00018000, 0, 0);
      drain();
   endtask

   task automatic test_random(int count);
      for (int k = 0; k < count; k++) begin
         int unsigned p;
         logic signed [DATA_W-1:0] t;
         p = $urandom_range(7);
         t = ($urandom_range(3) == 0) ? rand_word() : $signed($urandom_range(15)) <<< 14;
         case ($urandom_range(19))
            0:       send_item(OP_CLEAR, p, rand_word(), $urandom, rand_word());
            1:       send_item(OP_NONE, p, rand_word(), $urandom, rand_word());
            2, 3, 4, 5, 6, 7, 8, 9:
                     send_item(OP_WRITE, p, t, $urandom, rand_word());
            default: send_item(OP_QUERY, p, t, $urandom, rand_word());
         endcase
      end
   endtask

   task automatic test_backpressure;
      hold_off_cycles = 400;
      test_random(20);
   endtask

   initial begin
      for (int p = 0; p < PROPERTIES; p++) begin
         chan_cnt[p] = 0;
         for (int i = 0; i < KEYFRAMES; i++) kf_used[p][i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(80);  drain();
      send_idle_pct = 64; recv_stall_pct = 0;  test_random(70);  drain();
      send_idle_pct = 0;  recv_stall_pct = 64; test_random(70);  drain();
      send_idle_pct = 14; recv_stall_pct = 14; test_random(70);  drain();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure(); drain();
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
